// ===== rtl/sdqz_pkg.sv =====
// shared types, constants and control structs of the sample compressor
package sdqz_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int FRACTION_DIGITS_DEF = 6;
	localparam int RUN_LIMIT_DEF = 255;

	localparam int MODE_W = 3;
	localparam int DEC_W = 3;
	localparam int KEEP_W = 9;
	localparam int THR_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int POS_W = 8;

	// operating modes
	localparam logic [MODE_W-1:0] MODE_PASS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROUND = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DECIM = 3'd2;
	localparam logic [MODE_W-1:0] MODE_THR = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RUN = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECIMALS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          packet_end;
	} smp_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          has_value;
		logic                          last;
	} res_beat_t;

	typedef struct packed {
		logic [MODE_W-1:0]            mode;
		logic [DEC_W-1:0]             decimals_kept;
		logic [KEEP_W-1:0]            keep_interval;
		logic [THR_W-1:0]             zero_threshold;
		logic signed [CFG_DATA_W-1:0] run_marker;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FIN,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic       take;
		logic       step1;
		logic       step2;
		logic       step3;
		logic       load;
		logic [1:0] idx;
		logic       commit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] n_res;
	} dp_sts_t;

endpackage

// ===== rtl/sdqz_ctrl.sv =====
// controller: item sequencing, result beat emission and output valid
module sdqz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              smp_valid,
	output logic              smp_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  sdqz_pkg::dp_sts_t sts,
	output sdqz_pkg::dp_cmd_t cmd
);
	import sdqz_pkg::*;

	ctl_state_t state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic       res_valid_q;
	logic       slot_free;
	logic       finish;

	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		smp_stall = 1'b1;
		finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				smp_stall = 1'b0;
				if (smp_valid) begin
					cmd.take = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.step1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.step2 = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.step3 = 1'b1;
				cnt_d = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.n_res == 2'd0) begin
					finish = 1'b1;
				end else if (slot_free) begin
					cmd.load = 1'b1;
					cmd.idx = cnt_q;
					if (cnt_q == sts.n_res - 2'd1) begin
						finish = 1'b1;
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
				// next item overlaps the last beat of this one
				if (finish) begin
					cmd.commit = 1'b1;
					smp_stall = 1'b0;
					if (smp_valid) begin
						cmd.take = 1'b1;
						state_d = ST_MUL1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sdqz_dp.sv =====
// datapath: decimation counter, reciprocal rounding, threshold, zero runs, result register
module sdqz_dp #(
	parameter int FRACTION_DIGITS = sdqz_pkg::FRACTION_DIGITS_DEF,
	parameter int RUN_LIMIT = sdqz_pkg::RUN_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdqz_pkg::cfg_t      cfg,
	input  sdqz_pkg::dp_cmd_t   cmd,
	output sdqz_pkg::dp_sts_t   sts,
	input  sdqz_pkg::smp_beat_t smp,
	output sdqz_pkg::res_beat_t res
);
	import sdqz_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int RUN_W = $clog2(RUN_LIMIT + 1);
	localparam logic [63:0] ONES = (64'd1 << SB) - 64'd1;
	localparam logic [SB-1:0] POW10 [10] = '{
		SB'(64'd1), SB'(64'd10), SB'(64'd100), SB'(64'd1000), SB'(64'd10000),
		SB'(64'd100000), SB'(64'd1000000), SB'(64'd10000000), SB'(64'd100000000),
		SB'(64'd1000000000)
	};
	localparam logic [SB-1:0] RECIP [10] = '{
		SB'(ONES / 64'd1), SB'(ONES / 64'd10), SB'(ONES / 64'd100),
		SB'(ONES / 64'd1000), SB'(ONES / 64'd10000), SB'(ONES / 64'd100000),
		SB'(ONES / 64'd1000000), SB'(ONES / 64'd10000000),
		SB'(ONES / 64'd100000000), SB'(ONES / 64'd1000000000)
	};
	localparam logic [SB-1:0] POS_LIM = SB'(64'd1) << (SB - 1);
	localparam logic [SB-1:0] NEG_LIM = POS_LIM - SB'(64'd1);

	// decimation and run state
	logic [POS_W-1:0]  pos_q;
	logic [RUN_W-1:0]  run_q;

	// pipeline registers
	logic [SB-1:0]     sample_s1;
	logic              pe_s1;
	logic              keep_s1;
	logic              neg_s1;
	logic [SB-1:0]     n_s1;
	logic [SB-1:0]     step_s1;
	logic [SB-1:0]     recip_s1;
	logic [SB-1:0]     q_s2;
	logic [SB-1:0]     p_s3;
	logic [SB-1:0]     mag_s4;
	res_beat_t         res_q;

	logic [3:0]        k;
	logic [SB-1:0]     step;
	logic [SB-1:0]     half;
	logic [SB-1:0]     n_in;
	logic [KEEP_W-1:0] interval;
	logic [KEEP_W-1:0] pos_inc;
	logic [2*SB-1:0]   prod1;
	logic [2*SB-1:0]   prod2;
	logic [SB:0]       p_up;
	logic [SB-1:0]     q_mag;
	logic [SB-1:0]     lim;

	logic              round_en;
	logic              thr_en;
	logic              zero;
	logic [SB-1:0]     rval;
	logic [SB-1:0]     fval;
	logic              emit_val;
	logic              pair;
	logic [RUN_W-1:0]  run1;
	logic [RUN_W-1:0]  run_cnt;
	logic [RUN_W-1:0]  run_nx;
	logic [1:0]        n_res;
	res_beat_t         beat;

	// input side: step lookup, magnitude plus half step, interval position
	always_comb begin
		if (4'(cfg.decimals_kept) >= 4'(FRACTION_DIGITS)) begin
			k = 4'd0;
		end else begin
			k = 4'(FRACTION_DIGITS) - 4'(cfg.decimals_kept);
		end
		step = POW10[k];
		half = step >> 1;
		if (smp.sample[SB-1]) begin
			n_in = half - smp.sample;
		end else begin
			n_in = half + smp.sample;
		end
		if (cfg.keep_interval == '0) begin
			interval = KEEP_W'(1);
		end else if (cfg.keep_interval > KEEP_W'(256)) begin
			interval = KEEP_W'(256);
		end else begin
			interval = cfg.keep_interval;
		end
		pos_inc = KEEP_W'(pos_q) + KEEP_W'(1);
	end

	// quotient estimate is exact or one short
	assign prod1 = (2*SB)'(n_s1) * (2*SB)'(recip_s1);
	assign prod2 = (2*SB)'(q_s2) * (2*SB)'(step_s1);

	always_comb begin
		p_up = {1'b0, p_s3} + {1'b0, step_s1};
		if ({1'b0, n_s1} >= p_up) begin
			q_mag = p_up[SB-1:0];
		end else begin
			q_mag = p_s3;
		end
		lim = neg_s1 ? POS_LIM : NEG_LIM;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_s1 <= smp.sample;
			pe_s1 <= smp.packet_end;
			keep_s1 <= (pos_q == '0);
			neg_s1 <= smp.sample[SB-1];
			n_s1 <= n_in;
			step_s1 <= step;
			recip_s1 <= RECIP[k];
		end
		if (cmd.step1) begin
			q_s2 <= prod1[2*SB-1:SB];
		end
		if (cmd.step2) begin
			p_s3 <= prod2[SB-1:0];
		end
		if (cmd.step3) begin
			mag_s4 <= (q_mag > lim) ? lim : q_mag;
		end
		if (cmd.load) begin
			res_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			run_q <= '0;
		end else begin
			if (cmd.take) begin
				if (smp.packet_end || pos_inc >= interval) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
			if (cmd.commit) begin
				run_q <= run_nx;
			end
		end
	end

	// result plan of the current item
	always_comb begin
		round_en = (cfg.mode == MODE_ROUND) || (cfg.mode == MODE_THR) || (cfg.mode == MODE_RUN);
		thr_en = (cfg.mode == MODE_THR) || (cfg.mode == MODE_RUN);
		zero = thr_en && (mag_s4 <= SB'(cfg.zero_threshold));
		if (zero) begin
			rval = '0;
		end else if (neg_s1) begin
			rval = -mag_s4;
		end else begin
			rval = mag_s4;
		end
		fval = round_en ? rval : sample_s1;

		case (cfg.mode) inside
			MODE_DECIM, MODE_THR: emit_val = keep_s1;
			MODE_RUN: emit_val = keep_s1 && !zero;
			default: emit_val = 1'b1;
		endcase

		run1 = run_q + RUN_W'(1);
		pair = 1'b0;
		run_cnt = run_q;
		run_nx = run_q;
		if (cfg.mode == MODE_RUN) begin
			if (keep_s1 && !zero) begin
				pair = (run_q != '0);
				run_nx = '0;
			end else if (keep_s1) begin
				pair = (run1 >= RUN_W'(RUN_LIMIT)) || pe_s1;
				run_cnt = run1;
				run_nx = (run1 >= RUN_W'(RUN_LIMIT)) ? '0 : run1;
			end else begin
				pair = pe_s1 && (run_q != '0);
			end
		end
		if (pe_s1) begin
			run_nx = '0;
		end

		if (pair) begin
			n_res = emit_val ? 2'd3 : 2'd2;
		end else if (emit_val || pe_s1) begin
			n_res = 2'd1;
		end else begin
			n_res = 2'd0;
		end

		beat.has_value = 1'b1;
		beat.last = pe_s1 && (cmd.idx == n_res - 2'd1);
		if (pair && cmd.idx == 2'd0) begin
			beat.value = cfg.run_marker;
		end else if (pair && cmd.idx == 2'd1) begin
			beat.value = {{(SB-RUN_W){1'b0}}, run_cnt};
		end else if (emit_val) begin
			beat.value = fval;
		end else begin
			// empty end of packet
			beat.value = '0;
			beat.has_value = 1'b0;
		end
	end

	assign sts.n_res = n_res;
	assign res = res_q;

endmodule

// ===== rtl/sample_decimate_quantize_zero_rle_unit.sv =====
// top level: configuration registers, controller and datapath of the sample compressor
//
// Packet sample compressor. Each accepted sample beat passes the rounding steps
// (reciprocal multiply, step multiply, one-step correction and saturation) and then the
// emit state, which loads its result beats in turn while the result slot is free; the next
// sample is accepted in the cycle that loads the last result of the previous one, or in the
// emit state itself when there is none. Samples in modes 0, 2, 5, 6 and 7 take the same
// path and timing. The result register frees the input side while a finished beat waits on
// res_stall. The user must write registers through cfg_we/cfg_index/cfg_wdata only while
// no sample is in flight; the block itself does not enforce it.
module sample_decimate_quantize_zero_rle_unit #(
	parameter int FRACTION_DIGITS = sdqz_pkg::FRACTION_DIGITS_DEF,
	parameter int RUN_LIMIT = sdqz_pkg::RUN_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sdqz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdqz_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                smp_valid,
	output logic                                smp_stall,
	input  sdqz_pkg::smp_beat_t                 smp,
	output logic                                res_valid,
	input  logic                                res_stall,
	output sdqz_pkg::res_beat_t                 res
);
	import sdqz_pkg::*;

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_PASS;
			cfg_q.decimals_kept <= DEC_W'(6);
			cfg_q.keep_interval <= KEEP_W'(1);
			cfg_q.zero_threshold <= '0;
			cfg_q.run_marker <= {1'b1, {(CFG_DATA_W-1){1'b0}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: cfg_q.mode <= cfg_wdata[MODE_W-1:0];
				CFG_DECIMALS: cfg_q.decimals_kept <= cfg_wdata[DEC_W-1:0];
				CFG_KEEP: cfg_q.keep_interval <= cfg_wdata[KEEP_W-1:0];
				CFG_THRESHOLD: cfg_q.zero_threshold <= cfg_wdata[THR_W-1:0];
				CFG_MARKER: cfg_q.run_marker <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	sdqz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sdqz_dp #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.RUN_LIMIT       (RUN_LIMIT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts),
		.smp    (smp),
		.res    (res)
	);

	// busy right after a sample beat is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall |=> smp_stall)
		else $error("sample taken while previous one still in rounding");

	a_load_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.n_res != 2'd0)
		else $error("result beat loaded for an item with no results");

	// bare beat only closes a packet
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_value |-> res.last && res.value == '0)
		else $error("bare result beat without end of packet");

endmodule

// ===== dv/tb_sample_decimate_quantize_zero_rle_unit.sv =====
// testbench of the sample compressor: random packets checked beat by beat against a predictor
`timescale 1ns / 100ps

module tb_sample_decimate_quantize_zero_rle_unit;
	import sdqz_pkg::*;

	localparam longint LIM_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint LIM_LO = -LIM_HI - 1;
	localparam longint THR_MAX = (longint'(1) << THR_W) - 1;
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic smp_valid = 1'b0;
	logic smp_stall;
	smp_beat_t smp = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_beat_t res;

	// mirror of the registers and state of the block
	logic [MODE_W-1:0] m_mode;
	logic [DEC_W-1:0] m_dec;
	logic [KEEP_W-1:0] m_keep;
	logic [THR_W-1:0] m_thr;
	logic signed [CFG_DATA_W-1:0] m_marker;
	logic [POS_W-1:0] pos_in_ivl;
	int run_len;

	smp_beat_t smp_todo[$];
	res_beat_t res_due[$];
	res_beat_t step_out[$];
	res_beat_t mon_want;
	smp_beat_t drv_beat;
	logic drv_valid;

	int snd_pct = 20;
	int rcv_pct = 20;
	int snd_gap;
	int rcv_gap;
	int hold_req = 0;
	longint gen_step = 1;
	longint gen_thr = 0;

	int n_mismatch = 0;
	int n_in = 0;
	int n_out = 0;
	int n_configs = 0;
	int n_run_pairs = 0;
	int n_bare = 0;

	sample_decimate_quantize_zero_rle_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.smp(smp),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("timeout: run did not complete");
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint round_to_step(longint x);
		longint step, mag, q;
		int k;
		k = (m_dec >= FRACTION_DIGITS_DEF) ? 0 : FRACTION_DIGITS_DEF - m_dec;
		step = 1;
		for (int i = 0; i < k; i++)
			step *= 10;
		mag = (x < 0) ? -x : x;
		q = (mag + step / 2) / step * step;
		if (x < 0)
			return (q > -LIM_LO) ? LIM_LO : -q;
		return (q > LIM_HI) ? LIM_HI : q;
	endfunction

	function automatic void emit_value(longint v, logic has);
		res_beat_t b;
		b.value = v[SAMPLE_BITS-1:0];
		b.has_value = has;
		b.last = 1'b0;
		step_out.push_back(b);
	endfunction

	function automatic void emit_run_pair();
		emit_value(longint'(m_marker), 1'b1);
		emit_value(longint'(run_len), 1'b1);
		run_len = 0;
		n_run_pairs++;
	endfunction

	function automatic void compress_sample(smp_beat_t b);
		longint s, r;
		int ivl;
		logic kept;
		step_out.delete();
		s = longint'(b.sample);
		kept = (pos_in_ivl == 0);
		ivl = (m_keep == 0) ? 1 : ((m_keep > 256) ? 256 : int'(m_keep));
		if (b.packet_end || int'(pos_in_ivl) + 1 >= ivl)
			pos_in_ivl = '0;
		else
			pos_in_ivl++;
		case (m_mode)
			MODE_ROUND: begin
				emit_value(round_to_step(s), 1'b1);
			end
			MODE_DECIM: begin
				if (kept)
					emit_value(s, 1'b1);
			end
			MODE_THR, MODE_RUN: begin
				if (kept) begin
					r = round_to_step(s);
					if (((r < 0) ? -r : r) <= longint'(m_thr))
						r = 0;
					if (m_mode == MODE_THR) begin
						emit_value(r, 1'b1);
					end else if (r != 0) begin
						if (run_len != 0)
							emit_run_pair();
						emit_value(r, 1'b1);
					end else begin
						run_len++;
						if (run_len >= RUN_LIMIT_DEF)
							emit_run_pair();
					end
				end
				if (m_mode == MODE_RUN && b.packet_end && run_len != 0)
					emit_run_pair();
			end
			default: begin
				emit_value(s, 1'b1);
			end
		endcase
		if (b.packet_end) begin
			run_len = 0;
			if (step_out.size() == 0) begin
				emit_value(0, 1'b0);
				n_bare++;
			end
			step_out[step_out.size() - 1].last = 1'b1;
		end
		foreach (step_out[i])
			res_due.push_back(step_out[i]);
	endfunction

	function automatic void note_mismatch(string what, res_beat_t want, res_beat_t got);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("%0s at %0t: expected value %0d has_value %0b last %0b,",
				what, $time, want.value, want.has_value, want.last,
				" got value %0d has_value %0b last %0b",
				got.value, got.has_value, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_mode <= MODE_PASS;
			m_dec <= DEC_W'(FRACTION_DIGITS_DEF);
			m_keep <= KEEP_W'(1);
			m_thr <= '0;
			m_marker <= LIM_LO[CFG_DATA_W-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: m_mode <= cfg_wdata[MODE_W-1:0];
				CFG_DECIMALS: m_dec <= cfg_wdata[DEC_W-1:0];
				CFG_KEEP: m_keep <= cfg_wdata[KEEP_W-1:0];
				CFG_THRESHOLD: m_thr <= cfg_wdata[THR_W-1:0];
				CFG_MARKER: m_marker <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
			smp <= '0;
			snd_gap <= 0;
			pos_in_ivl = '0;
			run_len = 0;
		end else begin
			drv_valid = smp_valid;
			drv_beat = smp;
			if (smp_valid && !smp_stall) begin
				compress_sample(smp);
				n_in++;
				drv_valid = 1'b0;
			end
			if (!drv_valid) begin
				if (snd_gap > 0) begin
					snd_gap <= snd_gap - 1;
				end else if (smp_todo.size() != 0) begin
					if ($urandom_range(0, 99) < snd_pct) begin
						snd_gap <= $urandom_range(1, 18) - 1;
					end else begin
						drv_valid = 1'b1;
						drv_beat = smp_todo.pop_front();
					end
				end
			end
			smp_valid <= drv_valid;
			smp <= drv_beat;
		end
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rcv_gap <= 0;
		end else if (hold_req > 0) begin
			res_stall <= 1'b1;
			hold_req <= hold_req - 1;
		end else if (rcv_gap > 0) begin
			res_stall <= 1'b1;
			rcv_gap <= rcv_gap - 1;
		end else if ($urandom_range(0, 99) < rcv_pct / 3) begin
			res_stall <= 1'b1;
			rcv_gap <= $urandom_range(1, 18) - 1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_out++;
			if (res_due.size() == 0) begin
				note_mismatch("unexpected beat", '0, res);
			end else begin
				mon_want = res_due.pop_front();
				if (res.value !== mon_want.value || res.has_value !== mon_want.has_value ||
						res.last !== mon_want.last)
					note_mismatch("wrong beat", mon_want, res);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [MODE_W-1:0] md, int dk, int ki, longint zt, longint rm);
		write_reg(CFG_MODE, CFG_DATA_W'(md));
		write_reg(CFG_DECIMALS, CFG_DATA_W'(dk));
		write_reg(CFG_KEEP, CFG_DATA_W'(ki));
		write_reg(CFG_THRESHOLD, zt[CFG_DATA_W-1:0]);
		write_reg(CFG_MARKER, rm[CFG_DATA_W-1:0]);
		gen_step = 1;
		for (int i = dk; i < FRACTION_DIGITS_DEF; i++)
			gen_step *= 10;
		gen_thr = zt;
		n_configs++;
	endtask

	task automatic queue_sample(longint v, logic pe);
		smp_beat_t b;
		b.sample = v[SAMPLE_BITS-1:0];
		b.packet_end = pe;
		smp_todo.push_back(b);
	endtask

	function automatic longint pick_sample(int zero_pct);
		longint v;
		if ($urandom_range(0, 99) < zero_pct)
			return 0;
		case ($urandom_range(0, 6))
			0, 1: v = longint'($signed($urandom));
			2: v = $urandom_range(0, 3000);
			3: v = longint'($urandom_range(0, 2000)) * gen_step + gen_step / 2 +
				int'($urandom_range(0, 2)) - 1;
			4: v = gen_thr + int'($urandom_range(0, 2)) - 1;
			5: v = ($urandom_range(0, 1) != 0) ? LIM_HI : LIM_HI - 1;
			default: v = LIM_LO;
		endcase
		if ($urandom_range(0, 1) != 0)
			v = -v;
		return v;
	endfunction

	task automatic fill_packets(int n_items, int max_len, int zero_pct);
		int left, len;
		logic noisy;
		left = n_items;
		while (left > 0) begin
			len = $urandom_range(1, max_len);
			if (len > left)
				len = left;
			noisy = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++)
				queue_sample(pick_sample(zero_pct),
					noisy ? logic'($urandom_range(0, 1)) : (i == len - 1));
			left -= len;
		end
	endtask

	task automatic wait_drained();
		while (smp_todo.size() != 0 || smp_valid || res_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [MODE_W-1:0] mode_order[5];
		logic [MODE_W-1:0] md;
		int ki, zp;
		longint zt;
		mode_order = '{MODE_PASS, MODE_ROUND, MODE_DECIM, MODE_THR, MODE_RUN};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: pass through
		queue_sample(LIM_LO, 1'b0);
		queue_sample(LIM_HI, 1'b0);
		queue_sample(0, 1'b1);
		wait_drained();

		// rounding with saturation at both ends and halves away from zero
		set_config(MODE_ROUND, 3, 1, 0, LIM_LO);
		queue_sample(LIM_HI, 1'b0);
		queue_sample(LIM_LO, 1'b0);
		queue_sample(1500, 1'b0);
		queue_sample(-1500, 1'b0);
		queue_sample(1499, 1'b0);
		queue_sample(-2499, 1'b1);
		wait_drained();
		set_config(MODE_ROUND, 7, 1, 0, LIM_LO);
		queue_sample(123457, 1'b1);
		wait_drained();

		// zero runs with interval zero, threshold edge and most negative sample
		set_config(MODE_RUN, 6, 0, 1000, LIM_HI);
		queue_sample(0, 1'b0);
		queue_sample(1000, 1'b0);
		queue_sample(-1001, 1'b0);
		queue_sample(LIM_LO, 1'b0);
		queue_sample(0, 1'b1);
		wait_drained();

		// a pending run survives a mode change and is dropped at packet end
		queue_sample(5, 1'b0);
		queue_sample(0, 1'b0);
		wait_drained();
		set_config(MODE_THR, 6, 1, THR_MAX, LIM_HI);
		queue_sample(7, 1'b1);
		wait_drained();
		set_config(MODE_RUN, 6, 1, THR_MAX, LIM_HI);
		queue_sample(LIM_LO, 1'b1);
		wait_drained();

		// interval above 256 and a bare packet end
		set_config(MODE_DECIM, 6, 511, 0, 0);
		queue_sample(42, 1'b0);
		queue_sample(-42, 1'b1);
		wait_drained();
		set_config(MODE_SPARE, 6, 1, 0, 0);
		queue_sample(-1, 1'b1);
		wait_drained();

		for (int p = 0; p < 9; p++) begin
			md = (p < 5) ? mode_order[p] : MODE_W'($urandom_range(0, 7));
			case ($urandom_range(0, 5))
				0: ki = $urandom_range(0, 1);
				1, 2, 3: ki = $urandom_range(1, 9);
				4: ki = 256;
				default: ki = $urandom_range(257, 511);
			endcase
			case ($urandom_range(0, 4))
				0: zt = 0;
				1, 2: zt = $urandom_range(0, 5_000_000);
				3: zt = longint'($urandom) & THR_MAX;
				default: zt = THR_MAX;
			endcase
			set_config(md, (p == 0) ? 0 : $urandom_range(0, 7), ki, zt,
				longint'($signed($urandom)));
			snd_pct = (p == 8) ? 0 : ($urandom_range(0, 2) * 20);
			rcv_pct = (p == 8) ? 0 : ($urandom_range(0, 2) * 20);
			zp = (md == MODE_RUN || md == MODE_THR) ? 40 : 10;
			if (p == 3) begin
				snd_pct = 0;
				hold_req = 300;
			end
			if (p == 7) begin
				// one long packet of zeros so the run count reaches its cap
				set_config(MODE_RUN, $urandom_range(0, 7), 1, THR_MAX,
					longint'($signed($urandom)));
				for (int i = 0; i < 258; i++)
					queue_sample(0, i == 257);
			end else begin
				fill_packets(20, ($urandom_range(0, 3) == 0) ? 40 : 10, zp);
			end
			wait_drained();
		end

		$display("covered %0d sample beats over %0d register settings, %0d result beats checked",
			n_in, n_configs, n_out);
		$display("predicted %0d zero run pairs and %0d bare packet ends, %0d mismatches",
			n_run_pairs, n_bare, n_mismatch);
		if (n_mismatch == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sdqz_pkg.sv
rtl/sdqz_ctrl.sv
rtl/sdqz_dp.sv
rtl/sample_decimate_quantize_zero_rle_unit.sv
dv/tb_sample_decimate_quantize_zero_rle_unit.sv
